/* design/usd_pkg.sv */
// Shared constants and types for the tar stream deframer.
package usd_pkg;

    localparam int unsigned BlockBytesDef = 512;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_HDR  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_CERR = 2'd3;

    localparam logic [1:0] OS_SKIP = 2'd0;
    localparam logic [1:0] OS_POS  = 2'd1;
    localparam logic [1:0] OS_NEG  = 2'd2;
    localparam logic [1:0] OS_DONE = 2'd3;

    localparam int unsigned QDepth = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        last_of_member;
        logic [63:0] member_size;
        logic [54:0] data_blocks;
        logic [7:0]  link_type;
        logic        is_directory;
        logic        is_ustar;
        logic [8:0]  file_mode;
        logic [35:0] mod_time;
        logic [16:0] sum_computed;
        logic [23:0] sum_stored;
    } t_rec;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_DATA   = 3'b010,
        PH_SILENT = 3'b100
    } t_phase;

endpackage

/* design/ustar_stream_deframer.sv */
// Top level of the tar stream deframer.
//  channel | direction | handshake            | payload
//  input   | in        | i_valid / o_stall    | i_in_byte
//  result  | out       | o_valid / i_stall    | o_kind .. o_sum_stored
// One byte is taken each cycle while the two-entry record queue has room
// and no end or error record was made. Results pass the queue, then the back register.
// Reset is synchronous and clears block position, phase and queue.
// Output stalls fill the queue; the input then stalls until a slot frees.
module ustar_stream_deframer #(
    parameter int unsigned BLOCK_BYTES = usd_pkg::BlockBytesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic        o_last_of_member,
    output logic [63:0] o_member_size,
    output logic [54:0] o_data_blocks,
    output logic [7:0]  o_link_type,
    output logic        o_is_directory,
    output logic        o_is_ustar,
    output logic [8:0]  o_file_mode,
    output logic [35:0] o_mod_time,
    output logic [16:0] o_sum_computed,
    output logic [23:0] o_sum_stored
);
    logic room, push, qv, pop;
    usd_pkg::t_rec frec, qrec, orec;

    usd_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .i_byte(i_in_byte), .i_room(room),
        .o_push(push), .o_rec(frec)
    );
    usd_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_rec(frec), .o_room(room),
        .i_pop(pop), .o_valid(qv), .o_rec(qrec)
    );
    usd_back u_back (
        .i_clk, .i_rst_n, .i_valid(qv), .i_rec(qrec), .o_pop(pop),
        .i_stall, .o_valid, .o_rec(orec)
    );

    assign o_stall          = !room;
    assign o_kind           = orec.kind;
    assign o_data_byte      = orec.data_byte;
    assign o_last_of_member = orec.last_of_member;
    assign o_member_size    = orec.member_size;
    assign o_data_blocks    = orec.data_blocks;
    assign o_link_type      = orec.link_type;
    assign o_is_directory   = orec.is_directory;
    assign o_is_ustar       = orec.is_ustar;
    assign o_file_mode      = orec.file_mode;
    assign o_mod_time       = orec.mod_time;
    assign o_sum_computed   = orec.sum_computed;
    assign o_sum_stored     = orec.sum_stored;
endmodule

/* design/usd_front.sv */
// Front part: walks blocks, parses header fields and builds result records.
module usd_front #(
    parameter int unsigned BLOCK_BYTES = usd_pkg::BlockBytesDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_room,
    output logic          o_push,
    output usd_pkg::t_rec o_rec
);
    localparam int unsigned OW = $clog2(BLOCK_BYTES);

    usd_pkg::t_phase r_phase, n_phase;
    logic [OW-1:0] r_off;
    logic [16:0]   r_sum, n_sum;
    logic [35:0]   r_oct, n_oct;
    logic [1:0]    r_ost, n_ost;
    logic [63:0]   r_sacc, n_sacc;
    logic [63:0]   r_size, n_size;
    logic [35:0]   r_mtime, n_mtime;
    logic [15:0]   r_mode, n_mode;
    logic [63:0]   r_chk, n_chk;
    logic [7:0]    r_sflag, n_sflag;
    logic [7:0]    r_link, n_link;
    logic [7:0]    r_ns, n_ns;
    logic [54:0]   r_blk, n_blk;
    logic [63:0]   r_bytes, n_bytes;

    logic          take;
    logic [8:0]    off;
    logic [2:0]    fld;
    logic          fstart, fend, digit, blank, eqm;
    logic [7:0]    mref;
    logic [63:0]   fin_v;
    logic [63:0]   bx;
    logic          usepfx, slash, isdir, noblk;
    logic [55:0]   blocks_raw;
    logic [54:0]   blocks;
    logic [63:0]   bcap;
    usd_pkg::t_rec rec;
    logic          emit;

    assign take = i_valid && i_room && (r_phase != usd_pkg::PH_SILENT);
    assign off  = 9'(r_off);

    always_comb begin
        fld = 3'd0;
        if (off >= 9'd100 && off < 9'd108) fld = 3'd1;
        else if (off >= 9'd124 && off < 9'd136) fld = 3'd2;
        else if (off >= 9'd136 && off < 9'd148) fld = 3'd3;
        else if (off >= 9'd148 && off <= 9'd155) fld = 3'd4;
        fstart = (off == 9'd100) || (off == 9'd124) || (off == 9'd136) || (off == 9'd148);
        fend   = (off == 9'd107) || (off == 9'd135) || (off == 9'd147) || (off == 9'd155);
        digit  = (i_byte >= 8'h30) && (i_byte <= 8'h37);
        blank  = (i_byte == 8'h20) || (i_byte >= 8'd9 && i_byte <= 8'd13);
        unique case (off)
            9'd257:  mref = 8'h75;
            9'd258:  mref = 8'h73;
            9'd259:  mref = 8'h74;
            9'd260:  mref = 8'h61;
            9'd261:  mref = 8'h72;
            default: mref = 8'h00;
        endcase
        eqm = (i_byte == mref);
    end

    always_comb begin
        logic [1:0]  ost;
        logic [35:0] oct;
        logic        do_fin;
        n_phase = r_phase; n_sum = r_sum; n_oct = r_oct; n_ost = r_ost;
        n_sacc = r_sacc; n_size = r_size; n_mtime = r_mtime; n_mode = r_mode;
        n_chk = r_chk; n_sflag = r_sflag; n_link = r_link; n_ns = r_ns;
        n_blk = r_blk; n_bytes = r_bytes;
        emit = 1'b0; rec = '0; fin_v = '0;
        ost = r_ost; oct = r_oct; do_fin = 1'b0;
        usepfx = 1'b0; slash = 1'b0; isdir = 1'b0; noblk = 1'b0;
        blocks_raw = '0; blocks = '0; bcap = '0; bx = '0;
        if (r_phase == usd_pkg::PH_DATA) begin
            if (r_bytes != 64'd0) begin
                emit = 1'b1;
                rec.kind = usd_pkg::KIND_DATA;
                rec.data_byte = i_byte;
                rec.last_of_member = (r_bytes == 64'd1);
                n_bytes = r_bytes - 64'd1;
            end
            if (off == 9'(BLOCK_BYTES - 1)) begin
                if (r_blk <= 55'd1) begin
                    n_blk = '0;
                    n_phase = usd_pkg::PH_HEADER;
                end else begin
                    n_blk = r_blk - 55'd1;
                end
            end
        end else if (r_phase == usd_pkg::PH_HEADER) begin
            if (off == 9'd0) begin
                n_sum = '0; n_ns = '0; n_sacc = '0; n_mode = '0; n_chk = '0;
                n_sflag = '0; n_link = '0; n_size = '0; n_mtime = '0;
            end
            n_sum = n_sum + ((off >= 9'd148 && off <= 9'd155) ? 17'd32 : 17'(i_byte));
            if (off <= 9'd99) begin
                if (off == 9'd0 && i_byte == 8'd0) n_ns[0] = 1'b1;
                if (!n_ns[1]) begin
                    if (i_byte == 8'd0) n_ns[1] = 1'b1;
                    else n_ns[2] = (i_byte == 8'h2f);
                end
            end else if (off >= 9'd345 && off <= 9'd499) begin
                if (off == 9'd345 && i_byte == 8'd0) n_ns[3] = 1'b1;
                if (!n_ns[4]) begin
                    if (i_byte == 8'd0) n_ns[4] = 1'b1;
                    else n_ns[5] = (i_byte == 8'h2f);
                end
                if (off == 9'd499 && i_byte != 8'd0) n_ns[6] = 1'b1;
            end else if (off >= 9'd257 && off <= 9'd262) begin
                if (off == 9'd257) begin
                    if (eqm) n_ns[7] = 1'b1;
                end else if (!eqm) begin
                    n_ns[7] = 1'b0;
                end
            end
            if (off == 9'd156) n_link = i_byte;
            if (off == 9'd124) n_sflag = i_byte;
            if (off >= 9'd127 && off <= 9'd134) n_sacc = {n_sacc[55:0], i_byte};
            if (fld != 3'd0) begin
                if (fstart) begin
                    ost = usd_pkg::OS_SKIP;
                    oct = '0;
                end
                if (ost == usd_pkg::OS_SKIP) begin
                    if (blank) begin
                    end else if (i_byte == 8'h2b) ost = usd_pkg::OS_POS;
                    else if (i_byte == 8'h2d) ost = usd_pkg::OS_NEG;
                    else if (digit) begin
                        oct = 36'(i_byte[2:0]);
                        ost = usd_pkg::OS_POS;
                    end else do_fin = 1'b1;
                end else if (ost != usd_pkg::OS_DONE) begin
                    if (digit) oct = {oct[32:0], i_byte[2:0]};
                    else do_fin = 1'b1;
                end
                if (fend && ost != usd_pkg::OS_DONE) do_fin = 1'b1;
                if (do_fin) begin
                    fin_v = (ost == usd_pkg::OS_NEG) ? (64'd0 - 64'(oct)) : 64'(oct);
                    ost = usd_pkg::OS_DONE;
                    unique case (fld)
                        3'd1:    n_mode = fin_v[15:0];
                        3'd2:    n_size = fin_v;
                        3'd3:    n_mtime = fin_v[35:0];
                        default: n_chk = fin_v;
                    endcase
                end
                if (off == 9'd135) begin
                    if (n_sflag == 8'hff) n_size = '0;
                    else if (n_sflag == 8'h80) n_size = n_sacc;
                end
                n_oct = oct;
                n_ost = ost;
            end
            if (off == 9'(BLOCK_BYTES - 1)) begin
                emit = 1'b1;
                usepfx = n_ns[7] && !n_ns[3];
                if (!usepfx && n_ns[0]) begin
                    rec.kind = usd_pkg::KIND_END;
                    n_phase = usd_pkg::PH_SILENT;
                end else if (n_chk != 64'(n_sum)) begin
                    rec.kind = usd_pkg::KIND_CERR;
                    rec.sum_computed = n_sum;
                    rec.sum_stored = n_chk[23:0];
                    n_phase = usd_pkg::PH_SILENT;
                end else begin
                    if (usepfx && n_ns[6] && n_ns[4]) slash = n_ns[5];
                    else if (usepfx && n_ns[0]) slash = 1'b1;
                    else slash = n_ns[2];
                    isdir = (n_link == 8'h35) || slash || (n_mode[15:12] == 4'b0100);
                    noblk = isdir || n_link == 8'h31 || n_link == 8'h32
                         || n_link == 8'h73 || n_link == 8'h36;
                    blocks_raw = 56'(n_size >> 9) + 56'(n_size[8:0] != 9'd0);
                    if (!noblk) blocks = blocks_raw[55] ? {55{1'b1}} : blocks_raw[54:0];
                    bx = {blocks, 9'd0};
                    bcap = (n_size < bx) ? n_size : bx;
                    rec.kind = usd_pkg::KIND_HDR;
                    rec.member_size = n_size;
                    rec.data_blocks = blocks;
                    rec.link_type = n_link;
                    rec.is_directory = isdir;
                    rec.is_ustar = n_ns[7];
                    rec.file_mode = n_mode[8:0];
                    rec.mod_time = n_mtime;
                    rec.sum_computed = n_sum;
                    rec.sum_stored = n_chk[23:0];
                    n_blk = blocks;
                    n_bytes = bcap;
                    n_phase = (blocks != '0) ? usd_pkg::PH_DATA : usd_pkg::PH_HEADER;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= usd_pkg::PH_HEADER;
            r_off <= '0; r_sum <= '0; r_oct <= '0; r_ost <= usd_pkg::OS_SKIP;
            r_sacc <= '0; r_size <= '0; r_mtime <= '0; r_mode <= '0; r_chk <= '0;
            r_sflag <= '0; r_link <= '0; r_ns <= '0; r_blk <= '0; r_bytes <= '0;
        end else if (take) begin
            r_phase <= n_phase;
            r_off <= r_off + 1'b1;
            r_sum <= n_sum; r_oct <= n_oct; r_ost <= n_ost; r_sacc <= n_sacc;
            r_size <= n_size; r_mtime <= n_mtime; r_mode <= n_mode; r_chk <= n_chk;
            r_sflag <= n_sflag; r_link <= n_link; r_ns <= n_ns;
            r_blk <= n_blk; r_bytes <= n_bytes;
        end
    end

    assign o_push = take && emit;
    assign o_rec  = rec;
endmodule

/* design/usd_queue.sv */
// Short record queue between front and back.
module usd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  usd_pkg::t_rec i_rec,
    output logic          o_room,
    input  logic          i_pop,
    output logic          o_valid,
    output usd_pkg::t_rec o_rec
);
    usd_pkg::t_rec r_mem [usd_pkg::QDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_room  = (r_cnt != 2'(usd_pkg::QDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign o_rec   = r_mem[r_rp];
endmodule

/* design/usd_back.sv */
// Back part: output register that presents records on the result channel.
module usd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  usd_pkg::t_rec i_rec,
    output logic          o_pop,
    input  logic          i_stall,
    output logic          o_valid,
    output usd_pkg::t_rec o_rec
);
    logic r_valid;
    usd_pkg::t_rec r_rec;

    assign o_pop = i_valid && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_rec <= i_rec;
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;
endmodule

/* design/usd_checker.sv */
// Port-level checks for the tar stream deframer, bound to the top level.
module usd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_data_byte,
    input logic        o_last_of_member,
    input logic [54:0] o_data_blocks
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data_byte) && $stable(o_kind))
        else $error("stalled beat changed");
    a_last_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_member |-> o_kind == usd_pkg::KIND_DATA)
        else $error("last flag on non-data beat");
    a_end_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_kind == usd_pkg::KIND_END |=> !o_valid)
        else $error("beat after end record");
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_kind == usd_pkg::KIND_CERR |=> !o_valid)
        else $error("beat after checksum error");
    a_data_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == usd_pkg::KIND_DATA |-> o_data_blocks == '0)
        else $error("header field in data beat");
endmodule

bind ustar_stream_deframer usd_checker u_usd_checker (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_kind, .o_data_byte,
    .o_last_of_member, .o_data_blocks
);
